// File: rtl/assert_macros.svh
// Concurrent assertion helpers for the encoder tracker RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, off while reset is held.
`define EAVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define EAVT_ASSERT_IMP(lbl, ante, cons, msg) \
	`EAVT_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define EAVT_ASSERT_NXT(lbl, ante, cons, msg) \
	`EAVT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/eavt_pkg.sv
// Package for the encoder angle/velocity tracker.
// Field widths, register indexes and register reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eavt_pkg;

	localparam int unsigned CprW    = 17;
	localparam int unsigned RateW   = 27;
	localparam int unsigned TickW   = 24;
	localparam int unsigned RawW    = 16;
	localparam int unsigned ReqW    = 2;
	localparam int unsigned AngleW  = 48;
	localparam int unsigned VelW    = 32;
	localparam int unsigned TurnW   = 32;
	localparam int unsigned CfgAddrW = 2;
	localparam int unsigned CfgDataW = 27;

	// register indexes
	localparam logic [CfgAddrW-1:0] REG_CPR      = 2'd0;
	localparam logic [CfgAddrW-1:0] REG_RATE     = 2'd1;
	localparam logic [CfgAddrW-1:0] REG_MAX_TICK = 2'd2;
	localparam logic [CfgAddrW-1:0] REG_FB_TICK  = 2'd3;

	// request kinds
	localparam logic [ReqW-1:0] REQ_INIT  = 2'd0;
	localparam logic [ReqW-1:0] REQ_ANGLE = 2'd1;
	localparam logic [ReqW-1:0] REQ_VEL   = 2'd2;

	// register reset values
	localparam logic [CprW-1:0]  CPR_RST      = 17'd4096;
	localparam logic [RateW-1:0] RATE_RST     = 27'd9000000;
	localparam logic [TickW-1:0] MAX_TICK_RST = 24'd4500000;
	localparam logic [TickW-1:0] FB_TICK_RST  = 24'd9000;

	// quotient bits produced by the divider
	localparam int unsigned QuotW = 33;

endpackage

`default_nettype wire

// File: rtl/encoder_angle_velocity_tracker.sv
// Multi-turn angle and velocity tracker for an absolute single-turn encoder.
// Uses eavt_pkg and assert_macros.svh.
//
//   channel   dir  tdata (low bit up)                  tuser
//   s_axis    in   raw_count[15:0], timer_value[23:0]  req_type[1:0]
//   m_axis    out  angle_counts[47:0], velocity[31:0]  velocity_saturated
//   cfg       in   cfg_we / cfg_addr / cfg_data        -
//
// Velocity requests take two passes through the shared 33x28 multiplier and
// then the 33-step restoring divider, skipped when the rate is zero or the
// result saturates. One beat in flight; s_axis_tready only while idle.
// A finished beat waits in the output register while the core goes idle.
// Reset clears control, turn count and history registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module encoder_angle_velocity_tracker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// raw_count[15:0], timer_value[39:16]
	input  wire logic [39:0]                       s_axis_tdata,
	// req_type[1:0]
	input  wire logic [eavt_pkg::ReqW-1:0]         s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// angle_counts[47:0], velocity[79:48]
	output logic [79:0]                            m_axis_tdata,
	// velocity_saturated[0]
	output logic                                   m_axis_tuser,
	input  wire logic                              cfg_we,
	input  wire logic [eavt_pkg::CfgAddrW-1:0]     cfg_addr,
	input  wire logic [eavt_pkg::CfgDataW-1:0]     cfg_data
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_WRAP    = 4'd1;
	localparam logic [3:0] S_MUL_ANG = 4'd2;
	localparam logic [3:0] S_ANG     = 4'd3;
	localparam logic [3:0] S_DELTA   = 4'd4;
	localparam logic [3:0] S_MUL_LO  = 4'd5;
	localparam logic [3:0] S_MUL_HI  = 4'd6;
	localparam logic [3:0] S_ACC     = 4'd7;
	localparam logic [3:0] S_CHK     = 4'd8;
	localparam logic [3:0] S_DIV     = 4'd9;
	localparam logic [3:0] S_VEL     = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	localparam int unsigned AccW = 75;
	localparam int unsigned ProdW = 61;

	logic [3:0] state_q;

	// configuration
	logic [eavt_pkg::CprW-1:0]  cpr_q;
	logic [eavt_pkg::RateW-1:0] rate_q;
	logic [eavt_pkg::TickW-1:0] max_tick_q;
	logic [eavt_pkg::TickW-1:0] fb_tick_q;

	// history
	logic [eavt_pkg::RawW-1:0]   last_raw_q;
	logic [eavt_pkg::TurnW-1:0]  turn_q;
	logic [eavt_pkg::AngleW-1:0] last_angle_q;
	logic [eavt_pkg::TickW-1:0]  last_timer_q;

	// working registers
	logic [eavt_pkg::ReqW-1:0]   req_q;
	logic [eavt_pkg::RawW-1:0]   raw_q;
	logic [eavt_pkg::TickW-1:0]  tmr_q;
	logic [eavt_pkg::TickW-1:0]  ticks_q;
	logic [eavt_pkg::AngleW-1:0] angle_q;
	logic [eavt_pkg::AngleW-1:0] mag_q;
	logic                        neg_q;
	logic [ProdW-1:0]            prod_q;
	logic [AccW-1:0]             acc_q;
	logic [eavt_pkg::TickW-1:0]  rem_q;
	logic [eavt_pkg::QuotW-1:0]  sh_q;
	logic [5:0]                  cnt_q;
	logic [eavt_pkg::VelW-1:0]   vel_q;
	logic                        sat_q;

	// output register
	logic                        out_valid_q;
	logic [eavt_pkg::AngleW-1:0] out_angle_q;
	logic [eavt_pkg::VelW-1:0]   out_vel_q;
	logic                        out_sat_q;

	// combinational
	logic [eavt_pkg::RawW-1:0]   raw_in;
	logic [eavt_pkg::TickW-1:0]  tmr_in;
	logic [eavt_pkg::RawW-1:0]   jump;
	logic [eavt_pkg::CprW+1:0]   jump5;
	logic [eavt_pkg::CprW+1:0]   cpr4;
	logic [eavt_pkg::TickW-1:0]  elapsed;
	logic [eavt_pkg::TickW-1:0]  ticks_sel;
	logic [eavt_pkg::AngleW-1:0] delta;
	logic signed [32:0]          mul_a;
	logic signed [27:0]          mul_b;
	logic signed [ProdW-1:0]     mul_p;
	logic [eavt_pkg::TickW:0]    div_t;
	logic                        div_ge;
	logic [eavt_pkg::TickW:0]    div_d;
	logic [eavt_pkg::QuotW-1:0]  lim;
	logic [eavt_pkg::VelW-1:0]   vmag;
	logic                        load_out;

	assign raw_in = s_axis_tdata[15:0];
	assign tmr_in = s_axis_tdata[39:16];

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_vel_q, out_angle_q};
	assign m_axis_tuser  = out_sat_q;

	assign jump  = (raw_q >= last_raw_q) ? (raw_q - last_raw_q) : (last_raw_q - raw_q);
	assign jump5 = {1'b0, jump, 2'b00} + {3'b000, jump};
	assign cpr4  = {cpr_q, 2'b00};

	assign elapsed = last_timer_q - tmr_q;
	always_comb begin
		ticks_sel = elapsed;
		if (elapsed == '0 || elapsed > max_tick_q) begin
			ticks_sel = fb_tick_q;
		end
		if (ticks_sel == '0) begin
			ticks_sel = eavt_pkg::TickW'(1);
		end
	end

	assign delta = angle_q - last_angle_q;

	// shared multiplier
	always_comb begin
		case (state_q)
			S_MUL_ANG: begin
				mul_a = {turn_q[eavt_pkg::TurnW-1], turn_q};
				mul_b = {11'd0, cpr_q};
			end
			S_MUL_LO: begin
				mul_a = {9'd0, mag_q[23:0]};
				mul_b = {1'b0, rate_q};
			end
			default: begin
				mul_a = {9'd0, mag_q[47:24]};
				mul_b = {1'b0, rate_q};
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// restoring divider step
	assign div_t  = {rem_q, sh_q[eavt_pkg::QuotW-1]};
	assign div_ge = (div_t >= {1'b0, ticks_q});
	assign div_d  = div_t - {1'b0, ticks_q};

	assign lim  = neg_q ? 33'h080000000 : 33'h07fffffff;
	assign vmag = (sh_q > lim) ? lim[eavt_pkg::VelW-1:0] : sh_q[eavt_pkg::VelW-1:0];

	assign load_out = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q      <= eavt_pkg::CPR_RST;
			rate_q     <= eavt_pkg::RATE_RST;
			max_tick_q <= eavt_pkg::MAX_TICK_RST;
			fb_tick_q  <= eavt_pkg::FB_TICK_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				eavt_pkg::REG_CPR:      cpr_q      <= cfg_data[eavt_pkg::CprW-1:0];
				eavt_pkg::REG_RATE:     rate_q     <= cfg_data;
				eavt_pkg::REG_MAX_TICK: max_tick_q <= cfg_data[eavt_pkg::TickW-1:0];
				eavt_pkg::REG_FB_TICK:  fb_tick_q  <= cfg_data[eavt_pkg::TickW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_raw_q   <= '0;
			turn_q       <= '0;
			last_angle_q <= '0;
			last_timer_q <= '0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					last_raw_q <= raw_q;
					if (req_q == eavt_pkg::REQ_INIT) begin
						turn_q       <= '0;
						last_timer_q <= '0;
						state_q      <= S_DONE;
					end else begin
						if (jump5 > cpr4) begin
							turn_q <= (raw_q > last_raw_q) ? turn_q - 1'b1 : turn_q + 1'b1;
						end
						state_q <= S_MUL_ANG;
					end
				end
				S_MUL_ANG: state_q <= S_ANG;
				S_ANG: begin
					state_q <= (req_q == eavt_pkg::REQ_VEL) ? S_DELTA : S_DONE;
				end
				S_DELTA: begin
					last_angle_q <= angle_q;
					last_timer_q <= tmr_q;
					state_q      <= S_MUL_LO;
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_ACC;
				S_ACC:    state_q <= S_CHK;
				S_CHK: begin
					if (rate_q == '0 || acc_q[AccW-1:eavt_pkg::QuotW] >= {18'd0, ticks_q}) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= 6'(eavt_pkg::QuotW);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 6'd1) begin
						state_q <= S_VEL;
					end
				end
				S_VEL: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= s_axis_tuser;
				raw_q <= raw_in;
				tmr_q <= tmr_in;
			end
			S_WRAP: begin
				ticks_q <= ticks_sel;
				angle_q <= {32'd0, raw_q};
				vel_q   <= '0;
				sat_q   <= 1'b0;
			end
			S_ANG: begin
				angle_q <= prod_q[eavt_pkg::AngleW-1:0] + {32'd0, raw_q};
			end
			S_DELTA: begin
				neg_q <= delta[eavt_pkg::AngleW-1];
				mag_q <= delta[eavt_pkg::AngleW-1] ? (~delta + 1'b1) : delta;
			end
			S_MUL_HI: begin
				acc_q <= {24'd0, prod_q[50:0]};
			end
			S_ACC: begin
				acc_q <= acc_q + {prod_q[50:0], 24'd0};
			end
			S_CHK: begin
				rem_q <= acc_q[eavt_pkg::QuotW +: eavt_pkg::TickW];
				sh_q  <= acc_q[eavt_pkg::QuotW-1:0];
				if (rate_q != '0 && acc_q[AccW-1:eavt_pkg::QuotW] >= {18'd0, ticks_q}) begin
					sat_q <= 1'b1;
					vel_q <= neg_q ? 32'h80000000 : 32'h7fffffff;
				end
			end
			S_DIV: begin
				rem_q <= div_ge ? div_d[eavt_pkg::TickW-1:0] : div_t[eavt_pkg::TickW-1:0];
				sh_q  <= {sh_q[eavt_pkg::QuotW-2:0], div_ge};
			end
			S_VEL: begin
				sat_q <= (sh_q > lim);
				vel_q <= neg_q ? (~vmag + 1'b1) : vmag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_angle_q <= angle_q;
			out_vel_q   <= vel_q;
			out_sat_q   <= sat_q;
		end
	end

	`EAVT_ASSERT_NXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready, "core still ready after accepting a beat")
	`EAVT_ASSERT_IMP(a_div_cnt, state_q == S_DIV, cnt_q != '0, "divider running with zero step count")
	`EAVT_ASSERT_IMP(a_rem_below, state_q == S_DIV, rem_q < ticks_q, "divider remainder not below divisor")
	`EAVT_ASSERT_IMP(a_sat_value, m_axis_tvalid && m_axis_tuser, m_axis_tdata[79:48] == 32'h7fffffff || m_axis_tdata[79:48] == 32'h80000000, "saturated velocity not at a limit")

endmodule

`default_nettype wire
